// ----- rtl/core/mips_ir_execute_unit_core_defines.svh -----
// Assertion macros for the execute unit core.
// Used by the top level only; no other dependencies.
`ifndef MIPS_IR_EXECUTE_UNIT_CORE_DEFINES_SVH
`define MIPS_IR_EXECUTE_UNIT_CORE_DEFINES_SVH
`ifndef SYNTH
`define MIEU_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("mieu assertion failed");
`define MIEU_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("mieu forbidden condition seen");
`else
`define MIEU_ASSERT(lbl, clk, rst_n, prop)
`define MIEU_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- rtl/core/mieu_pkg.sv -----
// Shared types, opcodes and helper functions of the execute unit.
// No dependencies.
package mieu_pkg;

	localparam int NREGS = 32;
	localparam int RIDX_W = 5;

	typedef enum logic [4:0] {
		FN_NOP      = 5'd0,
		FN_ADDW     = 5'd1,
		FN_OR       = 5'd2,
		FN_AND      = 5'd3,
		FN_LUI      = 5'd4,
		FN_MOVEHILO = 5'd5,
		FN_MTSAH    = 5'd6,
		FN_PADDU    = 5'd7,
		FN_MOVBITS  = 5'd8,
		FN_FADD     = 5'd9,
		FN_STORE    = 5'd10,
		FN_FALL     = 5'd11,
		FN_BEQ      = 5'd12,
		FN_JUMP     = 5'd13,
		FN_CALL     = 5'd14,
		FN_IJUMP    = 5'd15,
		FN_ICALL    = 5'd16
	} func_e;

	typedef enum logic [2:0] {
		DK_GPR   = 3'd0,
		DK_HI    = 3'd1,
		DK_LO    = 3'd2,
		DK_HI1   = 3'd3,
		DK_LO1   = 3'd4,
		DK_FPR   = 3'd5,
		DK_FCR31 = 3'd6
	} dkind_e;

	localparam logic [4:0] LINK_REG = 5'd31;

	typedef struct packed {
		logic [4:0]         func;
		logic               a_is_imm;
		logic [4:0]         reg_a;
		logic signed [63:0] imm_a;
		logic               b_is_imm;
		logic [4:0]         reg_b;
		logic signed [63:0] imm_b;
		logic [2:0]         dest_kind;
		logic [4:0]         dest_reg;
		logic [31:0]        instr_pc;
		logic [31:0]        jump_pc;
		logic [31:0]        second_pc;
	} instr_t;

	typedef struct packed {
		logic        status;
		logic        mem_write;
		logic [31:0] mem_addr;
		logic [63:0] mem_data_low;
		logic [63:0] mem_data_high;
		logic [31:0] store_pc;
		logic        next_pc_valid;
		logic [31:0] next_pc;
	} result_t;

	typedef struct packed {
		logic              en_lo;
		logic              en_hi;
		logic [RIDX_W-1:0] addr;
		logic [63:0]       lo;
		logic [63:0]       hi;
	} gpr_wr_t;

	typedef struct packed {
		logic              en;
		logic [RIDX_W-1:0] addr;
		logic [31:0]       data;
	} fpr_wr_t;

	typedef struct packed {
		logic [63:0] a_lo;
		logic [63:0] a_hi;
		logic [63:0] b_lo;
		logic [63:0] b_hi;
		logic [31:0] fa;
		logic [31:0] fb;
	} rd_data_t;

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hffff_ffff : s[31:0];
	endfunction

	function automatic logic [63:0] sat_add_half(input logic [63:0] a, input logic [63:0] b);
		return {sat_add32(a[63:32], b[63:32]), sat_add32(a[31:0], b[31:0])};
	endfunction

	function automatic logic [63:0] sext32(input logic [31:0] w);
		return {{32{w[31]}}, w};
	endfunction

endpackage

// ----- rtl/core/mieu_in_if.sv -----
// Input channel: one decoded instruction per item.
// Depends on nothing but the valid/ready handshake.
interface mieu_in_if;
	logic               valid;
	logic               ready;
	logic [4:0]         func;
	logic               a_is_imm;
	logic [4:0]         reg_a;
	logic signed [63:0] imm_a;
	logic               b_is_imm;
	logic [4:0]         reg_b;
	logic signed [63:0] imm_b;
	logic [2:0]         dest_kind;
	logic [4:0]         dest_reg;
	logic [31:0]        instr_pc;
	logic [31:0]        jump_pc;
	logic [31:0]        second_pc;

	modport source (output valid, func, a_is_imm, reg_a, imm_a, b_is_imm, reg_b, imm_b,
		dest_kind, dest_reg, instr_pc, jump_pc, second_pc, input ready);
	modport sink (input valid, func, a_is_imm, reg_a, imm_a, b_is_imm, reg_b, imm_b,
		dest_kind, dest_reg, instr_pc, jump_pc, second_pc, output ready);
endinterface

// ----- rtl/core/mieu_out_if.sv -----
// Output channel: one execution result per item.
// Depends on nothing but the valid/ready handshake.
interface mieu_out_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic        mem_write;
	logic [31:0] mem_addr;
	logic [63:0] mem_data_low;
	logic [63:0] mem_data_high;
	logic [31:0] store_pc;
	logic        next_pc_valid;
	logic [31:0] next_pc;

	modport source (output valid, status, mem_write, mem_addr, mem_data_low, mem_data_high,
		store_pc, next_pc_valid, next_pc, input ready);
	modport sink (input valid, status, mem_write, mem_addr, mem_data_low, mem_data_high,
		store_pc, next_pc_valid, next_pc, output ready);
endinterface

// ----- rtl/core/mieu_regfile.sv -----
// General (128-bit, split low/high) and float register files in synchronous RAMs.
// Per-entry valid bits give the zero reset; one write bypass per file. Uses mieu_pkg.
module mieu_regfile (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rd_en,
	input  logic [mieu_pkg::RIDX_W-1:0]    ra,
	input  logic [mieu_pkg::RIDX_W-1:0]    rb,
	input  mieu_pkg::gpr_wr_t              gwr,
	input  mieu_pkg::fpr_wr_t              fwr,
	output mieu_pkg::rd_data_t             rd
);
	import mieu_pkg::*;

	logic [63:0] glo_mem [NREGS];
	logic [63:0] ghi_mem [NREGS];
	logic [31:0] fpr_mem [NREGS];

	logic [NREGS-1:0] glo_vld_q, ghi_vld_q, fpr_vld_q;
	logic [RIDX_W-1:0] ra_q, rb_q;
	logic [63:0] alo_q, ahi_q, blo_q, bhi_q;
	logic [31:0] fa_q, fb_q;
	logic alo_v_q, ahi_v_q, blo_v_q, bhi_v_q, fa_v_q, fb_v_q;

	// last write of each file; equals RAM content until the next write replaces it
	gpr_wr_t gbyp_q;
	fpr_wr_t fbyp_q;

	always_ff @(posedge clk) begin
		if (gwr.en_lo) glo_mem[gwr.addr] <= gwr.lo;
		if (gwr.en_hi) ghi_mem[gwr.addr] <= gwr.hi;
		if (fwr.en) fpr_mem[fwr.addr] <= fwr.data;
		if (rd_en) begin
			alo_q <= glo_mem[ra];
			ahi_q <= ghi_mem[ra];
			blo_q <= glo_mem[rb];
			bhi_q <= ghi_mem[rb];
			fa_q <= fpr_mem[ra];
			fb_q <= fpr_mem[rb];
			ra_q <= ra;
			rb_q <= rb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glo_vld_q <= '0;
			ghi_vld_q <= '0;
			fpr_vld_q <= '0;
			alo_v_q <= 1'b0;
			ahi_v_q <= 1'b0;
			blo_v_q <= 1'b0;
			bhi_v_q <= 1'b0;
			fa_v_q <= 1'b0;
			fb_v_q <= 1'b0;
			gbyp_q <= '0;
			fbyp_q <= '0;
		end else begin
			if (gwr.en_lo) glo_vld_q[gwr.addr] <= 1'b1;
			if (gwr.en_hi) ghi_vld_q[gwr.addr] <= 1'b1;
			if (fwr.en) fpr_vld_q[fwr.addr] <= 1'b1;
			if (rd_en) begin
				alo_v_q <= glo_vld_q[ra];
				ahi_v_q <= ghi_vld_q[ra];
				blo_v_q <= glo_vld_q[rb];
				bhi_v_q <= ghi_vld_q[rb];
				fa_v_q <= fpr_vld_q[ra];
				fb_v_q <= fpr_vld_q[rb];
			end
			// a write to another address replaces the older bypass entry entirely; a same-address write keeps the other half
			if (gwr.en_lo || gwr.en_hi) begin
				gbyp_q.addr <= gwr.addr;
				if (gwr.en_lo) gbyp_q.lo <= gwr.lo;
				if (gwr.en_hi) gbyp_q.hi <= gwr.hi;
				gbyp_q.en_lo <= gwr.en_lo || (gbyp_q.en_lo && gbyp_q.addr == gwr.addr);
				gbyp_q.en_hi <= gwr.en_hi || (gbyp_q.en_hi && gbyp_q.addr == gwr.addr);
			end
			if (fwr.en) begin
				fbyp_q.en <= 1'b1;
				fbyp_q.addr <= fwr.addr;
				fbyp_q.data <= fwr.data;
			end
		end
	end

	// bypass entries with a mismatched half keep the RAM value for that half;
	// the RAM read is then current because the last write did not touch that half
	always_comb begin
		rd.a_lo = (gbyp_q.en_lo && gbyp_q.addr == ra_q) ? gbyp_q.lo : (alo_v_q ? alo_q : '0);
		rd.a_hi = (gbyp_q.en_hi && gbyp_q.addr == ra_q) ? gbyp_q.hi : (ahi_v_q ? ahi_q : '0);
		rd.b_lo = (gbyp_q.en_lo && gbyp_q.addr == rb_q) ? gbyp_q.lo : (blo_v_q ? blo_q : '0);
		rd.b_hi = (gbyp_q.en_hi && gbyp_q.addr == rb_q) ? gbyp_q.hi : (bhi_v_q ? bhi_q : '0);
		if (ra_q == '0) begin
			rd.a_lo = '0;
			rd.a_hi = '0;
		end
		if (rb_q == '0) begin
			rd.b_lo = '0;
			rd.b_hi = '0;
		end
		rd.fa = (fbyp_q.en && fbyp_q.addr == ra_q) ? fbyp_q.data : (fa_v_q ? fa_q : '0);
		rd.fb = (fbyp_q.en && fbyp_q.addr == rb_q) ? fbyp_q.data : (fb_v_q ? fb_q : '0);
	end

endmodule

// ----- rtl/core/mieu_fadd.sv -----
// Two-stage single-precision adder, round to nearest even, feeding the float accumulator.
// Stage one aligns and adds, stage two normalizes and rounds. Uses mieu_pkg.
module mieu_fadd (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] x,
	input  logic [31:0] y
);
	import mieu_pkg::*;

	localparam logic [31:0] QNAN_DEF = 32'hffc0_0000;
	localparam logic [31:0] QUIET_BIT = 32'h0040_0000;

	logic        v_s1;
	logic        sgn_s1;
	logic [9:0]  exp_s1;
	logic [27:0] mag_s1;
	logic        spec_s1;
	logic [31:0] spec_val_s1;
	logic [31:0] acc_q;

	logic [7:0]  ex, ey;
	logic [23:0] mx, my;
	logic        xnan, ynan, xinf, yinf, swap;
	logic [7:0]  el, es, d;
	logic [26:0] vl, vs, vs_sh, lost_mask;
	logic        sticky;
	logic [27:0] mag;
	logic [31:0] spec_val;
	logic        spec;
	logic        big_s;

	always_comb begin
		ex = x[30:23];
		ey = y[30:23];
		mx = {ex != 8'd0, x[22:0]};
		my = {ey != 8'd0, y[22:0]};
		xnan = ex == 8'hff && x[22:0] != '0;
		ynan = ey == 8'hff && y[22:0] != '0;
		xinf = ex == 8'hff && x[22:0] == '0;
		yinf = ey == 8'hff && y[22:0] == '0;
		swap = {ey, my} > {ex, mx};
		el = swap ? (ey == 8'd0 ? 8'd1 : ey) : (ex == 8'd0 ? 8'd1 : ex);
		es = swap ? (ex == 8'd0 ? 8'd1 : ex) : (ey == 8'd0 ? 8'd1 : ey);
		big_s = swap ? y[31] : x[31];
		vl = {(swap ? my : mx), 3'b000};
		vs = {(swap ? mx : my), 3'b000};
		d = el - es;
		vs_sh = vs >> d;
		lost_mask = (d >= 8'd27) ? '1 : ((27'd1 << d) - 27'd1);
		sticky = (vs & lost_mask) != '0;
		vs_sh[0] = vs_sh[0] | sticky;
		mag = (x[31] ^ y[31]) ? ({1'b0, vl} - {1'b0, vs_sh}) : ({1'b0, vl} + {1'b0, vs_sh});
		spec = 1'b1;
		if (xnan) spec_val = x | QUIET_BIT;
		else if (ynan) spec_val = y | QUIET_BIT;
		else if (xinf && yinf && (x[31] ^ y[31])) spec_val = QNAN_DEF;
		else if (xinf) spec_val = x;
		else if (yinf) spec_val = y;
		else if (mag == '0) spec_val = {x[31] & y[31], 31'd0};
		else begin
			spec = 1'b0;
			spec_val = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sgn_s1 <= big_s;
			exp_s1 <= {2'b00, el};
			mag_s1 <= mag;
			spec_s1 <= spec;
			spec_val_s1 <= spec_val;
		end
	end

	function automatic logic [4:0] lzc27(input logic [26:0] v);
		logic [4:0] n;
		logic       seen;
		n = 5'd0;
		seen = 1'b0;
		for (int i = 26; i >= 0; i--) begin
			if (!seen && !v[i]) n = n + 5'd1;
			if (v[i]) seen = 1'b1;
		end
		return n;
	endfunction

	logic [26:0] m1, m2;
	logic [9:0]  e1, e2, room;
	logic [4:0]  lz, sh;
	logic [30:0] ef, efr;
	logic        inc;
	logic [31:0] res;

	always_comb begin
		if (mag_s1[27]) begin
			m1 = {mag_s1[27:2], mag_s1[1] | mag_s1[0]};
			e1 = exp_s1 + 10'd1;
		end else begin
			m1 = mag_s1[26:0];
			e1 = exp_s1;
		end
		lz = lzc27(m1);
		room = e1 - 10'd1;
		sh = ({5'd0, lz} < room) ? lz : room[4:0];
		m2 = m1 << sh;
		e2 = e1 - {5'd0, sh};
		ef = {(m2[26] ? e2[7:0] : 8'd0), m2[25:3]};
		inc = m2[2] && (m2[1] || m2[0] || m2[3]);
		efr = ef + {30'd0, inc};
		if (spec_s1) res = spec_val_s1;
		else if (e2 >= 10'd255) res = {sgn_s1, 8'hff, 23'd0};
		else res = {sgn_s1, efr};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			acc_q <= '0;
		end else begin
			v_s1 <= start;
			if (v_s1) acc_q <= res;
		end
	end

endmodule

// ----- rtl/core/mips_ir_execute_unit_core.sv -----
// Execute unit core: an accepted item is held in the execute stage, then in the output register.
// Throughput one item per cycle unless the receiver stalls; register RAM reads are issued at
// accept, and the execute stage writes back as it hands its result to the output register.
// Reset: asynchronous, clears valid bits, so all register files read as zero.
// Depends on mieu_pkg, mieu_in_if, mieu_out_if, mieu_regfile, mieu_fadd and the defines header.
`include "mips_ir_execute_unit_core_defines.svh"
module mips_ir_execute_unit_core (
	input  logic       clk,
	input  logic       arst_n,
	mieu_in_if.sink    in_ch,
	mieu_out_if.source out_ch
);
	import mieu_pkg::*;

	logic     s1_v;
	instr_t   ins_s1;
	instr_t   ins_in;
	logic     out_v_q;
	result_t  out_q;
	result_t  res;
	rd_data_t rd;
	gpr_wr_t  gwr;
	fpr_wr_t  fwr;
	logic     advance, accept, fadd_go;

	logic [63:0] hilo_q [4];
	logic [3:0]  sa_q;
	logic [31:0] fcr_q;

	assign advance = s1_v && (!out_v_q || out_ch.ready);
	assign in_ch.ready = !s1_v || advance;
	assign accept = in_ch.valid && in_ch.ready;

	always_comb begin
		ins_in.func = in_ch.func;
		ins_in.a_is_imm = in_ch.a_is_imm;
		ins_in.reg_a = in_ch.reg_a;
		ins_in.imm_a = in_ch.imm_a;
		ins_in.b_is_imm = in_ch.b_is_imm;
		ins_in.reg_b = in_ch.reg_b;
		ins_in.imm_b = in_ch.imm_b;
		ins_in.dest_kind = in_ch.dest_kind;
		ins_in.dest_reg = in_ch.dest_reg;
		ins_in.instr_pc = in_ch.instr_pc;
		ins_in.jump_pc = in_ch.jump_pc;
		ins_in.second_pc = in_ch.second_pc;
	end

	mieu_regfile u_rf (
		.clk(clk), .arst_n(arst_n), .rd_en(accept),
		.ra(in_ch.reg_a), .rb(in_ch.reg_b), .gwr(gwr), .fwr(fwr), .rd(rd)
	);

	mieu_fadd u_fadd (
		.clk(clk), .arst_n(arst_n), .start(fadd_go), .x(rd.fa), .y(rd.fb)
	);

	logic [63:0] opa, opb;
	logic [31:0] sum32, st_sum;
	logic        wr_hilo, wr_sa, wr_fcr;

	always_comb begin
		opa = ins_s1.a_is_imm ? ins_s1.imm_a : rd.a_lo;
		opb = ins_s1.b_is_imm ? ins_s1.imm_b : rd.b_lo;
		sum32 = opa[31:0] + opb[31:0];
		st_sum = rd.a_lo[31:0] + ins_s1.imm_b[31:0];
		res = '0;
		gwr = '0;
		gwr.addr = ins_s1.dest_reg;
		fwr = '0;
		fwr.addr = ins_s1.dest_reg;
		fwr.data = rd.a_lo[31:0];
		wr_hilo = 1'b0;
		wr_sa = 1'b0;
		wr_fcr = 1'b0;
		fadd_go = 1'b0;
		case (ins_s1.func)
			FN_NOP: ;
			FN_ADDW: begin
				gwr.en_lo = 1'b1;
				gwr.lo = sext32(sum32);
			end
			FN_OR: begin
				gwr.en_lo = 1'b1;
				gwr.lo = opa | opb;
			end
			FN_AND: begin
				gwr.en_lo = 1'b1;
				gwr.lo = opa & opb;
			end
			FN_LUI: begin
				gwr.en_lo = 1'b1;
				gwr.lo = sext32({ins_s1.imm_a[15:0], 16'd0});
			end
			FN_MOVEHILO: wr_hilo = ins_s1.dest_kind == DK_HI || ins_s1.dest_kind == DK_LO ||
				ins_s1.dest_kind == DK_HI1 || ins_s1.dest_kind == DK_LO1;
			FN_MTSAH: wr_sa = 1'b1;
			FN_PADDU: begin
				gwr.en_lo = 1'b1;
				gwr.en_hi = 1'b1;
				gwr.lo = sat_add_half(rd.a_lo, rd.b_lo);
				gwr.hi = sat_add_half(rd.a_hi, rd.b_hi);
			end
			FN_MOVBITS: begin
				if (ins_s1.dest_kind == DK_FPR) fwr.en = 1'b1;
				else wr_fcr = 1'b1;
			end
			FN_FADD: fadd_go = 1'b1;
			FN_STORE: begin
				res.mem_write = 1'b1;
				res.mem_addr = {st_sum[31:4], 4'd0};
				res.mem_data_low = rd.b_lo;
				res.mem_data_high = rd.b_hi;
				res.store_pc = ins_s1.instr_pc;
			end
			FN_FALL: begin
				res.next_pc_valid = 1'b1;
				res.next_pc = ins_s1.second_pc;
			end
			FN_BEQ: begin
				res.next_pc_valid = 1'b1;
				res.next_pc = (rd.a_lo == rd.b_lo) ? ins_s1.jump_pc : ins_s1.second_pc;
			end
			FN_JUMP: begin
				res.next_pc_valid = 1'b1;
				res.next_pc = ins_s1.jump_pc;
			end
			FN_CALL: begin
				gwr.en_lo = 1'b1;
				gwr.addr = LINK_REG;
				gwr.lo = {32'd0, ins_s1.second_pc};
				res.next_pc_valid = 1'b1;
				res.next_pc = ins_s1.jump_pc;
			end
			FN_IJUMP: begin
				res.next_pc_valid = 1'b1;
				res.next_pc = rd.a_lo[31:0];
			end
			FN_ICALL: begin
				gwr.en_lo = 1'b1;
				gwr.lo = {32'd0, ins_s1.second_pc};
				res.next_pc_valid = 1'b1;
				res.next_pc = rd.a_lo[31:0];
			end
			default: res.status = 1'b1;
		endcase
		// register 0 is hardwired; the RAM write strobes only fire as the item leaves
		if (gwr.addr == '0) begin
			gwr.en_lo = 1'b0;
			gwr.en_hi = 1'b0;
		end
		gwr.en_lo = gwr.en_lo && advance;
		gwr.en_hi = gwr.en_hi && advance;
		fwr.en = fwr.en && advance;
		fadd_go = fadd_go && advance;
	end

	always_ff @(posedge clk) begin
		if (accept) ins_s1 <= ins_in;
		if (advance) out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
			out_v_q <= 1'b0;
			sa_q <= '0;
			fcr_q <= '0;
			for (int i = 0; i < 4; i++) hilo_q[i] <= '0;
		end else begin
			if (in_ch.ready) s1_v <= in_ch.valid;
			if (advance) out_v_q <= 1'b1;
			else if (out_ch.ready) out_v_q <= 1'b0;
			if (advance && wr_sa) sa_q <= {rd.a_lo[2:0] ^ ins_s1.imm_b[2:0], 1'b0};
			if (advance && wr_fcr) fcr_q <= rd.a_lo[31:0];
			if (advance && wr_hilo) hilo_q[2'(ins_s1.dest_kind - 3'd1)] <= rd.a_lo;
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.status = out_q.status;
	assign out_ch.mem_write = out_q.mem_write;
	assign out_ch.mem_addr = out_q.mem_addr;
	assign out_ch.mem_data_low = out_q.mem_data_low;
	assign out_ch.mem_data_high = out_q.mem_data_high;
	assign out_ch.store_pc = out_q.store_pc;
	assign out_ch.next_pc_valid = out_q.next_pc_valid;
	assign out_ch.next_pc = out_q.next_pc;

	`MIEU_NEVER(a_no_r0_write, clk, arst_n, (gwr.en_lo || gwr.en_hi) && gwr.addr == '0)
	`MIEU_ASSERT(a_adv_loads_out, clk, arst_n, advance |=> out_v_q)
	`MIEU_NEVER(a_err_clean, clk, arst_n, out_v_q && out_q.status && (out_q.mem_write || out_q.next_pc_valid))
	`MIEU_NEVER(a_wr_only_on_adv, clk, arst_n, (gwr.en_lo || fwr.en) && !s1_v)

endmodule

// ----- test/mips_ir_execute_unit_core_tb.sv -----
// Testbench for mips_ir_execute_unit_core: directed and random instruction streams.
// A local model of the general registers predicts every result item and checks it.
// Depends on mieu_pkg, mieu_in_if, mieu_out_if and the core RTL.
`timescale 1ns / 1ps
module mips_ir_execute_unit_core_tb;
	import mieu_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 10;

	logic clk;
	logic arst_n;
	int unsigned cycles = 0;
	int unsigned errors = 0;
	bit no_idle;

	mieu_in_if in_ch ();
	mieu_out_if out_ch ();

	mips_ir_execute_unit_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	// architectural state as the block should hold it
	logic [63:0] gpr_lo [32];
	logic [63:0] gpr_hi [32];
	logic [63:0] hilo [4];
	logic [3:0]  sa_reg;
	logic [31:0] fpr [32];
	logic [31:0] fcr31;

	result_t results_due[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic [63:0] gpr_read(logic [4:0] r);
		return (r == 5'd0) ? 64'd0 : gpr_lo[r];
	endfunction

	function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hffff_ffff : s[31:0];
	endfunction

	function automatic logic [63:0] lanes_add(logic [63:0] a, logic [63:0] b);
		return {add_sat(a[63:32], b[63:32]), add_sat(a[31:0], b[31:0])};
	endfunction

	// Executes one instruction on the local state and returns its result item.
	function automatic result_t execute_instr(instr_t it);
		result_t r;
		logic [63:0] opa, opb, tmp_lo, tmp_hi;
		logic [31:0] w;
		r = '0;
		opa = it.a_is_imm ? it.imm_a : gpr_read(it.reg_a);
		opb = it.b_is_imm ? it.imm_b : gpr_read(it.reg_b);
		case (it.func)
			FN_NOP: ;
			FN_ADDW: begin
				w = opa[31:0] + opb[31:0];
				if (it.dest_reg != 0) gpr_lo[it.dest_reg] = {{32{w[31]}}, w};
			end
			FN_OR: if (it.dest_reg != 0) gpr_lo[it.dest_reg] = opa | opb;
			FN_AND: if (it.dest_reg != 0) gpr_lo[it.dest_reg] = opa & opb;
			FN_LUI: begin
				w = {it.imm_a[15:0], 16'd0};
				if (it.dest_reg != 0) gpr_lo[it.dest_reg] = {{32{w[31]}}, w};
			end
			FN_MOVEHILO:
				if (it.dest_kind >= DK_HI && it.dest_kind <= DK_LO1)
					hilo[2'(it.dest_kind - 3'd1)] = gpr_read(it.reg_a);
			FN_MTSAH: begin
				tmp_lo = gpr_read(it.reg_a);
				sa_reg = {tmp_lo[2:0] ^ it.imm_b[2:0], 1'b0};
			end
			FN_PADDU: begin
				tmp_lo = lanes_add(gpr_read(it.reg_a), gpr_read(it.reg_b));
				tmp_hi = lanes_add(it.reg_a == 0 ? 64'd0 : gpr_hi[it.reg_a],
					it.reg_b == 0 ? 64'd0 : gpr_hi[it.reg_b]);
				if (it.dest_reg != 0) begin
					gpr_lo[it.dest_reg] = tmp_lo;
					gpr_hi[it.dest_reg] = tmp_hi;
				end
			end
			FN_MOVBITS: begin
				tmp_lo = gpr_read(it.reg_a);
				if (it.dest_kind == DK_FPR) fpr[it.dest_reg] = tmp_lo[31:0];
				else fcr31 = tmp_lo[31:0];
			end
			FN_FADD: ; // accumulator is not visible at the ports
			FN_STORE: begin
				tmp_lo = gpr_read(it.reg_a);
				w = tmp_lo[31:0] + it.imm_b[31:0];
				r.mem_write = 1'b1;
				r.mem_addr = {w[31:4], 4'd0};
				r.mem_data_low = gpr_read(it.reg_b);
				r.mem_data_high = (it.reg_b == 0) ? 64'd0 : gpr_hi[it.reg_b];
				r.store_pc = it.instr_pc;
			end
			FN_FALL: begin
				r.next_pc_valid = 1'b1;
				r.next_pc = it.second_pc;
			end
			FN_BEQ: begin
				r.next_pc_valid = 1'b1;
				r.next_pc = (gpr_read(it.reg_a) == gpr_read(it.reg_b)) ?
					it.jump_pc : it.second_pc;
			end
			FN_JUMP: begin
				r.next_pc_valid = 1'b1;
				r.next_pc = it.jump_pc;
			end
			FN_CALL: begin
				gpr_lo[LINK_REG] = {32'd0, it.second_pc};
				r.next_pc_valid = 1'b1;
				r.next_pc = it.jump_pc;
			end
			FN_IJUMP: begin
				tmp_lo = gpr_read(it.reg_a);
				r.next_pc_valid = 1'b1;
				r.next_pc = tmp_lo[31:0];
			end
			FN_ICALL: begin
				tmp_lo = gpr_read(it.reg_a); // target read before link
				if (it.dest_reg != 0) gpr_lo[it.dest_reg] = {32'd0, it.second_pc};
				r.next_pc_valid = 1'b1;
				r.next_pc = tmp_lo[31:0];
			end
			default: r.status = 1'b1;
		endcase
		return r;
	endfunction

	task automatic send_instr(instr_t it);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			@(negedge clk);
			in_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid = 1'b1;
		in_ch.func = it.func;
		in_ch.a_is_imm = it.a_is_imm;
		in_ch.reg_a = it.reg_a;
		in_ch.imm_a = it.imm_a;
		in_ch.b_is_imm = it.b_is_imm;
		in_ch.reg_b = it.reg_b;
		in_ch.imm_b = it.imm_b;
		in_ch.dest_kind = it.dest_kind;
		in_ch.dest_reg = it.dest_reg;
		in_ch.instr_pc = it.instr_pc;
		in_ch.jump_pc = it.jump_pc;
		in_ch.second_pc = it.second_pc;
		do @(posedge clk); while (!in_ch.ready);
		results_due.push_back(execute_instr(it));
	endtask

	function automatic logic [63:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 64'd0;
			1: return '1;
			2: return 64'h8000_0000_0000_0000;
			3: return 64'h7fff_ffff_ffff_ffff;
			4: return {32'd0, $urandom_range(0, 3)};
			5: return 64'h0000_0000_ffff_ffff;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic instr_t random_instr();
		instr_t it;
		it.func = ($urandom_range(0, 99) < 8) ? 5'($urandom_range(17, 31)) :
			5'($urandom_range(0, 16));
		it.a_is_imm = 1'($urandom_range(0, 1));
		it.b_is_imm = 1'($urandom_range(0, 1));
		// a small register pool makes results feed later items
		it.reg_a = $urandom_range(0, 1) ? 5'($urandom_range(0, 7)) : 5'($urandom);
		it.reg_b = $urandom_range(0, 1) ? 5'($urandom_range(0, 7)) : 5'($urandom);
		it.dest_reg = $urandom_range(0, 1) ? 5'($urandom_range(0, 7)) : 5'($urandom);
		it.imm_a = pick_value();
		it.imm_b = pick_value();
		it.dest_kind = 3'($urandom_range(0, 7));
		it.instr_pc = $urandom;
		it.jump_pc = $urandom;
		it.second_pc = $urandom;
		return it;
	endfunction

	function automatic instr_t make_instr(func_e f, logic [4:0] ra, logic [4:0] rb,
			logic [4:0] rd, logic [63:0] ia, logic [63:0] ib, logic ai, logic bi);
		instr_t it;
		it = random_instr();
		it.func = f;
		it.reg_a = ra;
		it.reg_b = rb;
		it.dest_reg = rd;
		it.imm_a = ia;
		it.imm_b = ib;
		it.a_is_imm = ai;
		it.b_is_imm = bi;
		return it;
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		result_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (results_due.size() == 0) begin
				$error("result item with none expected");
				errors++;
			end else begin
				e = results_due.pop_front();
				check_field("status", e.status, out_ch.status);
				check_field("mem_write", e.mem_write, out_ch.mem_write);
				check_field("mem_addr", e.mem_addr, out_ch.mem_addr);
				check_field("mem_data_low", e.mem_data_low, out_ch.mem_data_low);
				check_field("mem_data_high", e.mem_data_high, out_ch.mem_data_high);
				check_field("store_pc", e.store_pc, out_ch.store_pc);
				check_field("next_pc_valid", e.next_pc_valid, out_ch.next_pc_valid);
				check_field("next_pc", e.next_pc, out_ch.next_pc);
			end
		end
	end

	// receiver stalls
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				@(negedge clk);
				out_ch.ready = 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			out_ch.ready = 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	task automatic test_alu_extremes();
		send_instr(make_instr(FN_NOP, 0, 0, 0, 0, 0, 0, 0));
		send_instr(make_instr(FN_ADDW, 0, 0, 1, 64'h7fff_ffff, 64'd1, 1, 1));
		send_instr(make_instr(FN_ADDW, 0, 0, 2, '1, 64'h8000_0000_0000_0000, 1, 1));
		send_instr(make_instr(FN_OR, 1, 2, 3, 0, 0, 0, 0));
		send_instr(make_instr(FN_AND, 3, 0, 4, 0, '1, 0, 1));
		send_instr(make_instr(FN_LUI, 0, 0, 5, 64'h1234_5678_9abc_8001, 0, 1, 1));
		send_instr(make_instr(FN_ADDW, 0, 0, 0, 64'd5, 64'd5, 1, 1)); // r0 write dropped
		send_instr(make_instr(FN_OR, 0, 0, 6, '1, 64'h0, 1, 1));
		send_instr(make_instr(FN_PADDU, 6, 6, 7, 0, 0, 0, 0)); // saturates
		send_instr(make_instr(FN_PADDU, 1, 5, 0, 0, 0, 0, 0));
	endtask

	task automatic test_side_regs();
		instr_t it;
		for (int k = 0; k < 8; k++) begin
			it = make_instr(k[0] ? FN_MOVEHILO : FN_MOVBITS, 6, 0, 5'(k), 0, '1, 0, 0);
			it.dest_kind = 3'(k);
			send_instr(it);
		end
		send_instr(make_instr(FN_MTSAH, 3, 0, 0, 0, 64'h5, 0, 0));
		send_instr(make_instr(FN_FADD, 0, 31, 0, 0, 0, 0, 0));
	endtask

	task automatic test_store_and_flow();
		send_instr(make_instr(FN_STORE, 7, 7, 0, 0, 64'hffff_ffff_8000_000f, 0, 0));
		send_instr(make_instr(FN_STORE, 0, 0, 0, 0, 64'h7fff_ffff, 0, 0));
		send_instr(make_instr(FN_FALL, 0, 0, 0, 0, 0, 0, 0));
		send_instr(make_instr(FN_BEQ, 3, 3, 0, 0, 0, 0, 0));
		send_instr(make_instr(FN_BEQ, 1, 2, 0, 0, 0, 0, 0));
		send_instr(make_instr(FN_JUMP, 0, 0, 0, 0, 0, 0, 0));
		send_instr(make_instr(FN_CALL, 0, 0, 0, 0, 0, 0, 0));
		send_instr(make_instr(FN_IJUMP, 31, 0, 0, 0, 0, 0, 0));
		send_instr(make_instr(FN_ICALL, 6, 0, 6, 0, 0, 0, 0)); // target before link
		send_instr(make_instr(FN_ICALL, 31, 0, 0, 0, 0, 0, 0));
		send_instr(make_instr(FN_STORE, 6, 7, 0, 0, 0, 0, 0));
		send_instr(make_instr(func_e'(5'd17), 0, 0, 0, 0, 0, 0, 0));
		send_instr(make_instr(func_e'(5'd31), 0, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_random_stream();
		for (int n = 0; n < 550; n++) begin
			if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
			send_instr(random_instr());
		end
		no_idle = 1'b0;
	endtask

	initial begin
		no_idle = 1'b0;
		for (int k = 0; k < 32; k++) begin
			gpr_lo[k] = '0;
			gpr_hi[k] = '0;
			fpr[k] = '0;
		end
		for (int k = 0; k < 4; k++) hilo[k] = '0;
		sa_reg = '0;
		fcr31 = '0;
		in_ch.valid = 1'b0;
		in_ch.func = '0;
		in_ch.a_is_imm = 1'b0;
		in_ch.reg_a = '0;
		in_ch.imm_a = '0;
		in_ch.b_is_imm = 1'b0;
		in_ch.reg_b = '0;
		in_ch.imm_b = '0;
		in_ch.dest_kind = '0;
		in_ch.dest_reg = '0;
		in_ch.instr_pc = '0;
		in_ch.jump_pc = '0;
		in_ch.second_pc = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_alu_extremes();
		test_side_regs();
		test_store_and_flow();
		test_random_stream();

		@(negedge clk);
		in_ch.valid = 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/mieu_pkg.sv
rtl/core/mieu_in_if.sv
rtl/core/mieu_out_if.sv
rtl/core/mieu_regfile.sv
rtl/core/mieu_fadd.sv
rtl/core/mips_ir_execute_unit_core.sv
test/mips_ir_execute_unit_core_tb.sv
